// ===== design/udtc_pkg.sv =====
// shared types, character constants and hex helpers for the url path decoder
`default_nettype none

package udtc_pkg;

  // characters the decoder reacts to
  localparam logic [7:0] CharPercent = 8'h25;  // '%'
  localparam logic [7:0] CharPlus    = 8'h2B;  // '+'
  localparam logic [7:0] CharSpace   = 8'h20;  // ' '
  localparam logic [7:0] CharQmark   = 8'h3F;  // '?'
  localparam logic [7:0] CharDot     = 8'h2E;  // '.'
  localparam logic [7:0] CharSlash   = 8'h2F;  // '/'
  localparam logic [7:0] CharBslash  = 8'h5C;  // '\'

  // most result words one input word can cause
  localparam int unsigned MaxResults = 3;

  // escape tracking, one-hot
  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_PCT  = 3'b010,
    ESC_HEX1 = 3'b100
  } esc_state_e;

  // segment tracking, one-hot
  typedef enum logic [3:0] {
    SEG_START  = 4'b0001,
    SEG_DOT    = 4'b0010,
    SEG_DOTDOT = 4'b0100,
    SEG_OTHER  = 4'b1000
  } seg_state_e;

  // decoded bytes produced by one input word, in order
  typedef struct packed {
    logic [1:0]                 cnt;
    logic [MaxResults-1:0][7:0] data;
    logic                       last;
  } cand_list_t;

  // one result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
    logic       traversal_found;
  } result_t;

  // result words produced by one input word
  typedef struct packed {
    logic [1:0]                cnt;
    result_t [MaxResults-1:0]  res;
  } result_list_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end
    hex_val = v[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/udtc_escape.sv =====
// percent and plus decoding: turns one raw byte into up to three decoded bytes
`default_nettype none

module udtc_escape (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   advance_i,
  input  wire logic [7:0]             byte_i,
  input  wire logic                   last_i,
  output udtc_pkg::cand_list_t        cand_o
);

  udtc_pkg::esc_state_e esc_q, esc_d;
  logic [7:0]           first_q, first_d;

  function automatic udtc_pkg::cand_list_t append(input udtc_pkg::cand_list_t l,
                                                  input logic [7:0] b);
    udtc_pkg::cand_list_t r;
    r = l;
    if (l.cnt != 2'(udtc_pkg::MaxResults)) begin
      r.data[l.cnt] = b;
      r.cnt         = l.cnt + 2'd1;
    end
    append = r;
  endfunction

  // escape decoding and end-of-target flush
  always_comb begin
    udtc_pkg::cand_list_t cl;
    logic                 raw;
    cl      = '0;
    cl.last = last_i;
    raw     = 1'b0;
    esc_d   = esc_q;
    first_d = first_q;
    case (esc_q)
      udtc_pkg::ESC_PCT: begin
        if (udtc_pkg::is_hex(byte_i)) begin
          first_d = byte_i;
          esc_d   = udtc_pkg::ESC_HEX1;
        end else begin
          cl  = append(cl, udtc_pkg::CharPercent);
          raw = 1'b1;
        end
      end
      udtc_pkg::ESC_HEX1: begin
        if (udtc_pkg::is_hex(byte_i)) begin
          cl    = append(cl, {udtc_pkg::hex_val(first_q), udtc_pkg::hex_val(byte_i)});
          esc_d = udtc_pkg::ESC_IDLE;
        end else begin
          cl  = append(cl, udtc_pkg::CharPercent);
          cl  = append(cl, first_q);
          raw = 1'b1;
        end
      end
      default: begin
        raw = 1'b1;
      end
    endcase
    // byte handled as fresh input
    if (raw) begin
      esc_d = udtc_pkg::ESC_IDLE;
      if (byte_i == udtc_pkg::CharPercent) begin
        esc_d = udtc_pkg::ESC_PCT;
      end else if (byte_i == udtc_pkg::CharPlus) begin
        cl = append(cl, udtc_pkg::CharSpace);
      end else begin
        cl = append(cl, byte_i);
      end
    end
    // an escape cut by the end goes out literally
    if (last_i) begin
      if (esc_d == udtc_pkg::ESC_PCT) begin
        cl = append(cl, udtc_pkg::CharPercent);
      end else if (esc_d == udtc_pkg::ESC_HEX1) begin
        cl = append(cl, udtc_pkg::CharPercent);
        cl = append(cl, first_d);
      end
      esc_d   = udtc_pkg::ESC_IDLE;
      first_d = 8'h00;
    end
    cand_o = cl;
  end

  // escape state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= udtc_pkg::ESC_IDLE;
      first_q <= 8'h00;
    end else if (advance_i) begin
      esc_q   <= esc_d;
      first_q <= first_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/udtc_path.sv =====
// query cut-off and dot-dot segment check over the decoded bytes
`default_nettype none

module udtc_path (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   advance_i,
  input  wire udtc_pkg::cand_list_t   cand_i,
  output udtc_pkg::result_list_t      res_o
);

  logic                 query_q, query_d;
  udtc_pkg::seg_state_e seg_q, seg_d;
  logic                 trav_q, trav_d;

  // walk the decoded bytes of this word in order
  always_comb begin
    udtc_pkg::result_list_t rl;
    logic [7:0]             b;
    rl      = '0;
    b       = 8'h00;
    query_d = query_q;
    seg_d   = seg_q;
    trav_d  = trav_q;
    for (int k = 0; k < udtc_pkg::MaxResults; k++) begin
      if ((2'(k) < cand_i.cnt) && !query_d) begin
        b = cand_i.data[k];
        if (b == udtc_pkg::CharQmark) begin
          query_d = 1'b1;
        end else begin
          if (b == udtc_pkg::CharSlash || b == udtc_pkg::CharBslash) begin
            if (seg_d == udtc_pkg::SEG_DOTDOT) begin
              trav_d = 1'b1;
            end
            seg_d = udtc_pkg::SEG_START;
          end else if (b == udtc_pkg::CharDot) begin
            case (seg_d)
              udtc_pkg::SEG_START:  seg_d = udtc_pkg::SEG_DOT;
              udtc_pkg::SEG_DOT:    seg_d = udtc_pkg::SEG_DOTDOT;
              default:              seg_d = udtc_pkg::SEG_OTHER;
            endcase
          end else begin
            seg_d = udtc_pkg::SEG_OTHER;
          end
          rl.res[rl.cnt].out_byte   = b;
          rl.res[rl.cnt].byte_valid = 1'b1;
          rl.cnt                    = rl.cnt + 2'd1;
        end
      end
    end
    // close the target: final flag on the last word, then clear
    if (cand_i.last) begin
      if (seg_d == udtc_pkg::SEG_DOTDOT) begin
        trav_d = 1'b1;
      end
      if (rl.cnt == 2'd0) begin
        rl.cnt = 2'd1;
      end
      rl.res[rl.cnt - 2'd1].out_last        = 1'b1;
      rl.res[rl.cnt - 2'd1].traversal_found = trav_d;
      query_d = 1'b0;
      seg_d   = udtc_pkg::SEG_START;
      trav_d  = 1'b0;
    end
    res_o = rl;
  end

  // path state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q <= 1'b0;
      seg_q   <= udtc_pkg::SEG_START;
      trav_q  <= 1'b0;
    end else if (advance_i) begin
      query_q <= query_d;
      seg_q   <= seg_d;
      trav_q  <= trav_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/udtc_outbuf.sv =====
// result register: holds one input word's results, hands out one a cycle if tready
`default_nettype none

module udtc_outbuf (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   load_i,
  input  wire udtc_pkg::result_list_t list_i,
  output logic                        can_load_o,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [7:0]                  m_axis_tdata_o,   // out_byte
  output logic                        m_axis_tlast_o,   // out_last
  output logic [1:0]                  m_axis_tuser_o    // byte_valid, traversal_found
);

  udtc_pkg::result_t [udtc_pkg::MaxResults-1:0] res_q;
  logic [1:0] cnt_q;
  logic [1:0] idx_q;
  logic       pop;
  logic       at_end;

  assign pop        = m_axis_tvalid_o && m_axis_tready_i;
  assign at_end     = (idx_q == cnt_q - 2'd1);
  assign can_load_o = (cnt_q == 2'd0) || (pop && at_end);

  // output word
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = res_q[idx_q].out_byte;
  assign m_axis_tlast_o  = res_q[idx_q].out_last;
  assign m_axis_tuser_o  = {res_q[idx_q].traversal_found, res_q[idx_q].byte_valid};

  // count and read index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= list_i.cnt;
      idx_q <= 2'd0;
    end else if (pop) begin
      if (at_end) begin
        cnt_q <= 2'd0;
        idx_q <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= list_i.res;
    end
  end

endmodule

`default_nettype wire

// ===== design/url_path_decode_and_traversal_check_core.sv =====
// top level: input register, escape decode, path check and result register
// an input word waits in the input register; its results go to the result register
// throughput: one input word per cycle while each gives at most one result word and
//   output is not stalled; a word with two or three results holds the input register
// the result register hands out one word a cycle unless stalled, so it sets the rate
// reset: asynchronous active low, clears all decode state and empties both registers
`default_nettype none

module url_path_decode_and_traversal_check_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // in_byte
  input  wire logic       s_axis_tlast_i,   // in_last
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // out_byte
  output logic            m_axis_tlast_o,   // out_last
  output logic [1:0]      m_axis_tuser_o    // [0] byte_valid, [1] traversal_found
);

  logic                   in_vld_q;
  logic [7:0]             in_byte_q;
  logic                   in_last_q;
  logic                   can_load;
  logic                   advance;
  udtc_pkg::cand_list_t   cand;
  udtc_pkg::result_list_t res_list;

  assign advance         = in_vld_q && can_load;
  assign s_axis_tready_o = !in_vld_q || advance;

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  udtc_escape u_escape (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .cand_o    (cand)
  );

  udtc_path u_path (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .cand_i    (cand),
    .res_o     (res_list)
  );

  udtc_outbuf u_outbuf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance),
    .list_i          (res_list),
    .can_load_o      (can_load),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ===== bench/tb_url_path_decode_and_traversal_check_core.sv =====
// testbench for the url path decoder: directed and random request targets, checked word by word
module tb_url_path_decode_and_traversal_check_core;

  localparam int unsigned RandomWords   = 380;
  localparam int unsigned StallCycles   = 160;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned DrainCycles   = 20;

  typedef logic [7:0] byte_q_t[$];

  // predicts decoded path words and checks them in order
  class url_decode_scoreboard;
    udtc_pkg::result_t    pending_results[$];
    udtc_pkg::result_t    step_results[$];
    int unsigned          mismatches;
    int unsigned          words_in;
    int unsigned          words_out;
    int unsigned          paths_done;
    int unsigned          traversals_seen;
    udtc_pkg::esc_state_e esc;
    logic [7:0]           held_digit;
    logic                 in_query;
    udtc_pkg::seg_state_e seg;
    logic                 dotdot_hit;

    function new();
      mismatches      = 0;
      words_in        = 0;
      words_out       = 0;
      paths_done      = 0;
      traversals_seen = 0;
      clear_path();
    endfunction

    function void clear_path();
      esc        = udtc_pkg::ESC_IDLE;
      held_digit = '0;
      in_query   = 1'b0;
      seg        = udtc_pkg::SEG_START;
      dotdot_hit = 1'b0;
    endfunction

    function bit hex_digit(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function logic [3:0] nibble_of(logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= "0" && c <= "9") v = c - "0";
      else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
      else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
      return v[3:0];
    endfunction

    // one decoded byte enters the segment tracker
    function void emit_path(logic [7:0] b);
      udtc_pkg::result_t r;
      if (in_query) return;
      if (b == udtc_pkg::CharQmark) begin
        in_query = 1'b1;
        return;
      end
      if (b == udtc_pkg::CharSlash || b == udtc_pkg::CharBslash) begin
        if (seg == udtc_pkg::SEG_DOTDOT) dotdot_hit = 1'b1;
        seg = udtc_pkg::SEG_START;
      end else if (b == udtc_pkg::CharDot) begin
        case (seg)
          udtc_pkg::SEG_START: seg = udtc_pkg::SEG_DOT;
          udtc_pkg::SEG_DOT:   seg = udtc_pkg::SEG_DOTDOT;
          default:             seg = udtc_pkg::SEG_OTHER;
        endcase
      end else begin
        seg = udtc_pkg::SEG_OTHER;
      end
      r            = '0;
      r.out_byte   = b;
      r.byte_valid = 1'b1;
      if (step_results.size() < udtc_pkg::MaxResults) step_results = {step_results, r};
    endfunction

    // raw byte with no escape pending
    function void take_raw(logic [7:0] b);
      if (b == udtc_pkg::CharPercent) esc = udtc_pkg::ESC_PCT;
      else if (b == udtc_pkg::CharPlus) emit_path(udtc_pkg::CharSpace);
      else emit_path(b);
    endfunction

    // accepted input word: queue the results it must cause
    function void note_word(logic [7:0] b, logic last);
      udtc_pkg::result_t r;
      int                n;
      step_results.delete();
      words_in++;
      case (esc)
        udtc_pkg::ESC_PCT: begin
          if (hex_digit(b)) begin
            held_digit = b;
            esc        = udtc_pkg::ESC_HEX1;
          end else begin
            esc = udtc_pkg::ESC_IDLE;
            emit_path(udtc_pkg::CharPercent);
            take_raw(b);
          end
        end
        udtc_pkg::ESC_HEX1: begin
          esc = udtc_pkg::ESC_IDLE;
          if (hex_digit(b)) begin
            emit_path({nibble_of(held_digit), nibble_of(b)});
          end else begin
            emit_path(udtc_pkg::CharPercent);
            emit_path(held_digit);
            take_raw(b);
          end
        end
        default: begin
          esc = udtc_pkg::ESC_IDLE;
          take_raw(b);
        end
      endcase
      if (last) begin
        // escape cut by the end goes out literally
        if (esc == udtc_pkg::ESC_PCT) begin
          emit_path(udtc_pkg::CharPercent);
        end else if (esc == udtc_pkg::ESC_HEX1) begin
          emit_path(udtc_pkg::CharPercent);
          emit_path(held_digit);
        end
        if (seg == udtc_pkg::SEG_DOTDOT) dotdot_hit = 1'b1;
        if (step_results.size() == 0) begin
          r = '0;
          step_results = {step_results, r};
        end
        n = step_results.size() - 1;
        step_results[n].out_last        = 1'b1;
        step_results[n].traversal_found = dotdot_hit;
        paths_done++;
        if (dotdot_hit) traversals_seen++;
        clear_path();
      end
      pending_results = {pending_results, step_results};
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // accepted result word against the oldest expectation
    function void check_word(logic [7:0] data, logic last, logic [1:0] user);
      udtc_pkg::result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual data=%h last=%b user=%b",
                 $time, data, last, user);
        return;
      end
      want = pending_results.pop_front();
      words_out++;
      cmp_field("out_byte", want.out_byte, data);
      cmp_field("byte_valid", {7'd0, want.byte_valid}, {7'd0, user[0]});
      cmp_field("out_last", {7'd0, want.out_last}, {7'd0, last});
      cmp_field("traversal_found", {7'd0, want.traversal_found}, {7'd0, user[1]});
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       s_axis_tvalid;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;
  logic [1:0] m_axis_tuser_o;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_req;
  int unsigned stall_ack;
  byte_q_t     path_buf;

  url_decode_scoreboard sb;

  url_path_decode_and_traversal_check_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver side: random back pressure, plus one long hold-off on request
  initial begin : rx_side
    int unsigned held;
    m_axis_tready = 1'b0;
    stall_ack     = 0;
    forever begin
      @(posedge clk);
      if (stall_req != stall_ack) begin
        m_axis_tready <= 1'b0;
        held = 0;
        while (held < StallCycles) begin
          @(posedge clk);
          held++;
        end
        stall_ack = stall_req;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result words checked between edges, where everything is stable
  always @(negedge clk) begin
    if (rst_n && m_axis_tvalid_o && m_axis_tready)
      sb.check_word(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
  end

  // watchdog on cycles with no word moving
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(negedge clk);
      if ((s_axis_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog, no word moved for %0d cycles", $time, WatchdogLimit);
    $display("FAIL url_path_decode_and_traversal_check_core");
    $finish;
  end

  // append one byte to the target being built
  function automatic void add_byte(input logic [7:0] b);
    path_buf = {path_buf, b};
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
    if (v < 4'd10) return "0" + v;
    return (upper ? "A" : "a") + v - 8'd10;
  endfunction

  // random target: mostly path pieces and well-formed escapes, some noise
  function automatic void build_random_path();
    int unsigned tokens;
    int unsigned k;
    logic [7:0]  v;
    tokens = $urandom_range(1, 8);
    repeat (tokens) begin
      k = $urandom_range(99);
      if (k < 25) begin
        add_byte((1'($urandom_range(1))) ? udtc_pkg::CharSlash : udtc_pkg::CharBslash);
      end else if (k < 45) begin
        add_byte(udtc_pkg::CharDot);
      end else if (k < 60) begin
        add_byte(8'("a" + $urandom_range(25)));
      end else if (k < 68) begin
        add_byte(udtc_pkg::CharPlus);
      end else if (k < 83) begin
        case ($urandom_range(4))
          0:       v = udtc_pkg::CharDot;
          1:       v = udtc_pkg::CharSlash;
          2:       v = udtc_pkg::CharBslash;
          3:       v = udtc_pkg::CharQmark;
          default: v = 8'($urandom_range(255));
        endcase
        add_byte(udtc_pkg::CharPercent);
        add_byte(hex_char(v[7:4], 1'($urandom_range(1))));
        add_byte(hex_char(v[3:0], 1'($urandom_range(1))));
      end else if (k < 90) begin
        // broken or cut escape
        add_byte(udtc_pkg::CharPercent);
        if (1'($urandom_range(1)))
          add_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
        if ($urandom_range(3) != 0) add_byte(8'($urandom_range(255)));
      end else if (k < 95) begin
        add_byte(udtc_pkg::CharQmark);
      end else begin
        add_byte(8'($urandom_range(255)));
      end
    end
  endfunction

  // offer one input word and wait for it to be taken
  task automatic send_word(input logic [7:0] b, input logic last);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_axis_tready_o;
      if (taken) sb.note_word(b, last);
      @(posedge clk);
    end
  endtask

  // send the buffered target, last mark on its final byte
  task automatic send_path();
    for (int i = 0; i < path_buf.size(); i++) send_word(path_buf[i], i == path_buf.size() - 1);
    path_buf.delete();
  endtask

  initial begin : main
    int unsigned directed_words;
    sb            = new();
    rst_n         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 68;
    stall_req     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // escaped dot closed by a slash
    put_text(".%2e/");
    send_path();
    // separator run, dot-dot closed by the end
    put_text("\\/..");
    send_path();
    // byte extremes, plus as space, uppercase escape
    add_byte(8'h00);
    put_text("+%41");
    add_byte(8'hFF);
    send_path();
    // escape broken after the percent and after one digit
    put_text("%G%4z");
    send_path();
    // broken by a new percent that the end cuts: three words at once
    put_text("%4%");
    send_path();
    // escaped query mark: nothing left to emit on the last byte
    put_text("%3F");
    send_path();
    // escape cut after one digit
    put_text("%a");
    send_path();
    directed_words = sb.words_in;

    // random targets through three idling phases
    while (sb.words_in - directed_words < RandomWords) begin
      if (sb.words_in - directed_words >= 2 * RandomWords / 3 && send_idle_pct != 0) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        stall_req     <= stall_req + 1;
      end else if (sb.words_in - directed_words >= RandomWords / 3 && send_idle_pct == 32) begin
        send_idle_pct <= 68;
        recv_idle_pct <= 32;
      end
      build_random_path();
      send_path();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d input words over %0d targets, %0d result words checked",
             sb.words_in, sb.paths_done, sb.words_out);
    $display("%0d targets flagged traversal, %0d mismatches", sb.traversals_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS url_path_decode_and_traversal_check_core");
    end else begin
      $display("FAIL url_path_decode_and_traversal_check_core");
    end
    $finish;
  end

endmodule
